// ----- rtl/krs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package krs_pkg;

  localparam int unsigned KEY_W    = 56;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned MOVES_W  = 3;
  localparam int unsigned OCC_W    = 4;

  typedef enum logic [0:0] {
    ACT_PUSH   = 1'b0,
    ACT_REMOVE = 1'b1
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_PUSHED    = 2'd0,
    ST_FULL      = 2'd1,
    ST_REMOVED   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // Clear every byte after the first zero byte, top byte first.
  function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] r;
    logic             live;
    r    = '0;
    live = 1'b1;
    for (int b = 6; b >= 0; b--) begin
      if (k[b*8 +: 8] == 8'h00) live = 1'b0;
      if (live) r[b*8 +: 8] = k[b*8 +: 8];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/krs_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

// One write port, one read port, registered read data.
module krs_mem #(
  parameter int unsigned DEPTH  = 8,
  parameter int unsigned DATA_W = 56,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/keyed_removal_stack.sv -----
`timescale 1ns / 1ps
`default_nettype none

// keyed_removal_stack: bounded stack of 56-bit keys with search-and-remove.
// Input channel (in_valid_i / in_stall_o) carries action_i and plate_key_i;
// a beat is taken when valid is high and stall is low. Keys are cut at their
// first zero byte before storing or comparing.
// Output channel (out_valid_o / out_stall_i) returns one beat per input beat:
// status_o, moves_o, occupancy_o, held steady while the receiver stalls.
// A push writes memory on acceptance if not full, then S_RESP loads the result
// register. A remove walks the entries: the search from the bottom to the
// match, then the compaction to the top. Every entry read uses the single
// memory read port and the shared comparator. in_stall_o is high while an
// item is in progress. The next beat is taken the cycle after the result
// register loads.
// A finished result waits in the sequencer until the output register is free,
// so a stalled receiver holds the block back by that much.
// Reset empties the stack and clears the output valid; stored keys are left
// as they were and are never read beyond the fill count.
module keyed_removal_stack
  import krs_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                action_i,
  input  wire logic [KEY_W-1:0]    plate_key_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic      [STATUS_W-1:0] status_o,
  output logic      [MOVES_W-1:0]  moves_o,
  output logic      [OCC_W-1:0]    occupancy_o
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SRD  = 6'b000010,  // search: read entry
    S_SCMP = 6'b000100,  // search: compare entry
    S_CRD  = 6'b001000,  // compact: read entry
    S_CCMP = 6'b010000,  // compact: compare, keep or drop
    S_RESP = 6'b100000   // hand result to output register
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0]    count_q, count_d;   // fill count
  logic [CNT_W-1:0]    idx_q, idx_d;       // read pointer
  logic [CNT_W-1:0]    wr_q, wr_d;         // compaction write pointer
  logic [MOVES_W-1:0]  moves_q, moves_d;
  status_e             res_q, res_d;
  logic [KEY_W-1:0]    key_q, key_d;

  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [MOVES_W-1:0]  omoves_q, omoves_d;
  logic [OCC_W-1:0]    occ_q, occ_d;

  logic                in_beat;
  logic                out_free;
  logic [KEY_W-1:0]    in_key;
  logic                hit;
  logic [CNT_W+3:0]    cnt_ext;

  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [KEY_W-1:0]    mem_wdata;
  logic                mem_re;
  logic [KEY_W-1:0]    mem_rdata;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_beat    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_key     = norm_key(plate_key_i);
  assign hit        = (mem_rdata == key_q);   // the shared comparator

  krs_mem #(
    .DEPTH (DEPTH),
    .DATA_W(KEY_W)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(idx_q[IDX_W-1:0]),
    .rdata_o(mem_rdata)
  );

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    wr_d      = wr_q;
    moves_d   = moves_q;
    res_d     = res_q;
    key_d     = key_q;
    mem_we    = 1'b0;
    mem_waddr = wr_q[IDX_W-1:0];
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          key_d   = in_key;
          idx_d   = '0;
          moves_d = '0;
          if (action_e'(action_i) == ACT_PUSH) begin
            state_d = S_RESP;
            if (count_q == CNT_FULL) begin
              res_d = ST_FULL;
            end else begin
              // Push lands straight in the top slot.
              mem_we    = 1'b1;
              mem_waddr = count_q[IDX_W-1:0];
              mem_wdata = in_key;
              count_d   = count_q + 1'b1;
              res_d     = ST_PUSHED;
            end
          end else begin
            state_d = S_SRD;
          end
        end
      end
      S_SRD: begin
        if (idx_q == count_q) begin
          res_d   = ST_NOT_FOUND;
          state_d = S_RESP;
        end else begin
          mem_re  = 1'b1;
          state_d = S_SCMP;
        end
      end
      S_SCMP: begin
        idx_d = idx_q + 1'b1;
        if (hit) begin
          wr_d    = idx_q;   // first match: compaction writes from here
          state_d = S_CRD;
        end else begin
          state_d = S_SRD;
        end
      end
      S_CRD: begin
        if (idx_q == count_q) begin
          count_d = wr_q;
          res_d   = ST_REMOVED;
          state_d = S_RESP;
        end else begin
          mem_re  = 1'b1;
          state_d = S_CCMP;
        end
      end
      S_CCMP: begin
        idx_d = idx_q + 1'b1;
        if (!hit) begin
          mem_we = 1'b1;
          wr_d   = wr_q + 1'b1;
          if (moves_q != '1) moves_d = moves_q + 1'b1;
        end
        state_d = S_CRD;
      end
      S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register: occupancy saturates at the field's top.
  assign cnt_ext = {4'b0000, count_q};

  always_comb begin
    out_valid_d = out_valid_q;
    status_d    = status_q;
    omoves_d    = omoves_q;
    occ_d       = occ_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (state_q == S_RESP && out_free) begin
      out_valid_d = 1'b1;
      status_d    = res_q;
      omoves_d    = (res_q == ST_REMOVED) ? moves_q : '0;
      occ_d       = (cnt_ext > (CNT_W + 4)'(15)) ? 4'hF : cnt_ext[OCC_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    wr_q     <= wr_d;
    moves_q  <= moves_d;
    res_q    <= res_d;
    key_q    <= key_d;
    status_q <= status_d;
    omoves_q <= omoves_d;
    occ_q    <= occ_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign moves_o     = omoves_q;
  assign occupancy_o = occ_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL)
    else $error("fill count beyond depth");

  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CCMP) |-> (wr_q < idx_q))
    else $error("compaction write pointer overtook read pointer");

  a_beat_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> (state_q != S_IDLE))
    else $error("sequencer idle after accepting a beat");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_RESP))
    else $error("result raised outside response state");
`endif

endmodule

`default_nettype wire

// ----- tb/stack_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of keyed_removal_stack, keeps a shadow copy of the
// stack and checks every result beat against the oldest outstanding one.
module stack_checker
  import krs_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_stall_i,
  input  wire logic                action_i,
  input  wire logic [KEY_W-1:0]    plate_key_i,
  input  wire logic                out_valid_i,
  input  wire logic                out_stall_i,
  input  wire logic [STATUS_W-1:0] status_i,
  input  wire logic [MOVES_W-1:0]  moves_i,
  input  wire logic [OCC_W-1:0]    occupancy_i,
  output int unsigned              err_count_o,
  output int unsigned              pending_o
);

  typedef struct packed {
    status_e            status;
    logic [MOVES_W-1:0] moves;
    logic [OCC_W-1:0]   occupancy;
  } stack_result_t;

  logic [KEY_W-1:0] shadow [DEPTH];
  int unsigned      depth_used;
  int unsigned      mismatches;
  stack_result_t    due_results [$];

  // Keep the characters up to the first NUL; everything after it is junk.
  function automatic logic [KEY_W-1:0] trim_key(input logic [KEY_W-1:0] k);
    int unsigned      chars;
    logic [KEY_W-1:0] keep_mask;
    chars = 7;
    for (int b = 6; b >= 0; b--)
      if (chars == 7 && k[b*8 +: 8] == 8'h00) chars = 6 - b;
    if (chars == 0) return '0;
    keep_mask = ~((KEY_W'(1) << ((7 - chars) * 8)) - KEY_W'(1));
    return k & keep_mask;
  endfunction

  function automatic stack_result_t apply_stack_op(input action_e          act,
                                                   input logic [KEY_W-1:0] raw);
    logic [KEY_W-1:0] key;
    stack_result_t    res;
    int               hit;
    int unsigned      kept;
    int unsigned      shifted;
    key        = trim_key(raw);
    res.status = ST_PUSHED;
    shifted    = 0;
    hit        = -1;
    if (act == ACT_PUSH) begin
      if (depth_used >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        shadow[depth_used] = key;
        depth_used++;
      end
    end else begin
      for (int i = 0; i < depth_used; i++)
        if (hit < 0 && shadow[i] == key) hit = i;
      if (hit < 0) begin
        res.status = ST_NOT_FOUND;
      end else begin
        // compact: equal entries above the hit go, the rest slide down
        kept = hit;
        for (int i = hit + 1; i < depth_used; i++) begin
          if (shadow[i] != key) begin
            shadow[kept] = shadow[i];
            kept++;
            shifted++;
          end
        end
        depth_used = kept;
        res.status = ST_REMOVED;
      end
    end
    res.moves     = (shifted > 7) ? MOVES_W'(7) : MOVES_W'(shifted);
    res.occupancy = (depth_used > 15) ? OCC_W'(15) : OCC_W'(depth_used);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    stack_result_t oldest;
    if (!rst_ni) begin
      depth_used = 0;
      mismatches = 0;
      due_results.delete();
      err_count_o <= 0;
      pending_o   <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (due_results.size() == 0) begin
          $error("unexpected result beat: status %0d moves %0d occupancy %0d",
                 status_i, moves_i, occupancy_i);
          mismatches++;
        end else begin
          oldest = due_results.pop_front();
          if (status_i !== oldest.status) begin
            $error("status: expected %0d, got %0d", oldest.status, status_i);
            mismatches++;
          end
          if (moves_i !== oldest.moves) begin
            $error("moves: expected %0d, got %0d", oldest.moves, moves_i);
            mismatches++;
          end
          if (occupancy_i !== oldest.occupancy) begin
            $error("occupancy: expected %0d, got %0d", oldest.occupancy, occupancy_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        due_results.push_back(apply_stack_op(action_e'(action_i), plate_key_i));
      err_count_o <= mismatches;
      pending_o   <= due_results.size();
    end
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

// Top of the keyed_removal_stack bench. This module only makes stimulus and
// calls the verdict; stack_checker does all prediction and comparison.
module testbench;
  import krs_pkg::*;

  localparam int unsigned DEPTH = 8;
  // Cycles without any beat on either channel before we give up. The slowest
  // remove walks every entry; the limit also covers long random gaps and stalls.
  localparam int unsigned STALL_LIMIT = 2000;
  // Drain time once nothing is outstanding.
  localparam int unsigned DRAIN_CYCLES = 40;

  // Directed keys: first character in the top byte, NUL-terminated if shorter than 7.
  localparam logic [KEY_W-1:0] KEY_NUL     = 56'h00_00_00_00_00_00_00;
  localparam logic [KEY_W-1:0] KEY_ONES    = 56'hFF_FF_FF_FF_FF_FF_FF;
  localparam logic [KEY_W-1:0] KEY_AB      = 56'h41_42_00_00_00_00_00;
  localparam logic [KEY_W-1:0] KEY_AB_JUNK = 56'h41_42_00_DE_AD_BE_EF;
  localparam logic [KEY_W-1:0] KEY_AB_ALT  = 56'h41_42_00_01_02_03_04;
  localparam logic [KEY_W-1:0] KEY_CD      = 56'h43_44_00_00_00_00_00;
  localparam logic [KEY_W-1:0] KEY_EF      = 56'h45_46_00_00_00_00_00;
  localparam logic [KEY_W-1:0] KEY_ZZ      = 56'h5A_5A_00_00_00_00_00;
  // leading NUL with live-looking bytes behind it: spells the empty string
  localparam logic [KEY_W-1:0] KEY_HIDDEN  = 56'h00_41_42_43_00_00_00;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  action_e             beat_action = ACT_PUSH;
  logic [KEY_W-1:0]    beat_key = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [MOVES_W-1:0]  moves;
  logic [OCC_W-1:0]    occupancy;

  int unsigned err_count;
  int unsigned pending;
  int unsigned quiet_cycles = 0;

  // Percentage of cycles in which the sender holds back / the receiver stalls.
  int unsigned send_gap_pct = 13;
  int unsigned stall_pct    = 74;

  // A small pool of names so that removes actually hit and duplicates pile up.
  logic [KEY_W-1:0] pool_key [5];
  int unsigned      pool_len [5];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  keyed_removal_stack #(
    .DEPTH (DEPTH)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .action_i    (beat_action),
    .plate_key_i (beat_key),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .status_o    (status),
    .moves_o     (moves),
    .occupancy_o (occupancy)
  );

  stack_checker #(
    .DEPTH (DEPTH)
  ) checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .action_i    (beat_action),
    .plate_key_i (beat_key),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .status_i    (status),
    .moves_i     (moves),
    .occupancy_i (occupancy),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  // Receiver back-pressure: a fresh coin each cycle, one assignment per edge.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: any beat on either side counts as progress.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [KEY_W-1:0] any_key();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[KEY_W-1:0];
  endfunction

  // A clean name of the given length, characters never NUL.
  function automatic logic [KEY_W-1:0] spell(input int unsigned chars);
    logic [KEY_W-1:0] k;
    k = '0;
    for (int c = 0; c < chars; c++) k[(6-c)*8 +: 8] = 8'($urandom_range(255, 1));
    return k;
  endfunction

  // Half the time, fill the bytes past the terminator with rubbish; the DUT
  // must treat the result as the same name.
  function automatic logic [KEY_W-1:0] with_junk(input logic [KEY_W-1:0] k,
                                                 input int unsigned      chars);
    logic [KEY_W-1:0] tail_mask;
    if (chars >= 7 || $urandom_range(1) == 0) return k;
    tail_mask = (KEY_W'(1) << ((6 - chars) * 8)) - KEY_W'(1);
    return k | (any_key() & tail_mask);
  endfunction

  task automatic renew_pool_slot(input int unsigned slot);
    pool_len[slot] = $urandom_range(7, 0);
    pool_key[slot] = spell(pool_len[slot]);
  endtask

  // Present one beat and hold it until the DUT takes it. Gaps are inserted
  // before the beat so valid never reacts to stall.
  task automatic offer(input action_e act, input logic [KEY_W-1:0] key);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    beat_action <= act;
    beat_key    <= key;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // Random traffic, mostly pool names. The push ratio swings every 30 beats
  // so the stack spends time both full and empty.
  task automatic random_burst(input int unsigned count);
    int unsigned      push_pct;
    int unsigned      slot;
    action_e          act;
    logic [KEY_W-1:0] key;
    push_pct = 55;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 30 == 0) begin
        case ($urandom_range(2))
          0:       push_pct = 25;
          1:       push_pct = 55;
          default: push_pct = 85;
        endcase
      end
      if (n % 40 == 0) renew_pool_slot($urandom_range(4));
      slot = $urandom_range(4);
      key  = ($urandom_range(99) < 85) ? with_junk(pool_key[slot], pool_len[slot])
                                       : any_key();
      act  = ($urandom_range(99) < push_pct) ? ACT_PUSH : ACT_REMOVE;
      offer(act, key);
    end
  endtask

  initial begin
    for (int s = 0; s < 5; s++) renew_pool_slot(s);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Phase one: sender mostly busy, receiver mostly stalling.
    send_gap_pct = 13;
    stall_pct    = 74;

    // Directed: remove on an empty stack, fill to the brim, push when full.
    offer(ACT_REMOVE, KEY_CD);
    offer(ACT_PUSH,   KEY_NUL);
    offer(ACT_PUSH,   KEY_ONES);
    offer(ACT_PUSH,   KEY_AB_JUNK);
    offer(ACT_PUSH,   KEY_AB);
    offer(ACT_PUSH,   KEY_CD);
    offer(ACT_PUSH,   KEY_ONES);
    offer(ACT_PUSH,   KEY_AB);
    offer(ACT_PUSH,   KEY_EF);
    offer(ACT_PUSH,   KEY_ZZ);
    // junk after the NUL must not matter; all three AB copies go at once
    offer(ACT_REMOVE, KEY_AB_ALT);
    offer(ACT_REMOVE, KEY_ZZ);
    // empty string sits at the bottom, so everything above it shifts
    offer(ACT_REMOVE, KEY_NUL);
    offer(ACT_REMOVE, KEY_EF);
    offer(ACT_REMOVE, KEY_ONES);
    offer(ACT_REMOVE, KEY_CD);
    offer(ACT_REMOVE, KEY_CD);
    offer(ACT_PUSH,   KEY_HIDDEN);
    offer(ACT_REMOVE, KEY_NUL);

    random_burst(330);

    // Phase two: roles swapped.
    send_gap_pct = 74;
    stall_pct    = 13;
    random_burst(350);

    // Phase three: back to back on both sides.
    send_gap_pct = 0;
    stall_pct    = 0;
    random_burst(350);

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    // every accepted beat must have had its result by now
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- keyed_removal_stack.f -----
rtl/krs_pkg.sv
rtl/krs_mem.sv
rtl/keyed_removal_stack.sv
tb/stack_checker.sv
tb/testbench.sv
